// ===== src/pitch_state_cost_engine_top_assert.svh =====
// Assertion macros for the pitch state cost engine.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PITCH_STATE_COST_ENGINE_TOP_ASSERT_SVH
`define PITCH_STATE_COST_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/psce_pkg.sv =====
// Shared constants, types and register codes of the pitch state cost engine.
// No dependencies; all other files but the assertion header import it.
`timescale 1ns / 1ps

package psce_pkg;

	localparam int MAX_STATES  = 64;
	localparam int STATE_W     = $clog2(MAX_STATES);
	localparam int STATE_IDX_W = 6;
	localparam int NREG_W      = 7;
	localparam int NOTE_W      = 8;
	localparam int COST_W      = 24;
	localparam int SUM_W       = 40;
	localparam int FIDX_W      = 16;
	localparam int CONF_W      = 16;
	localparam int WGT_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int DIFF_W      = NOTE_W + 2;
	localparam int ADIST_W     = NOTE_W + 1;
	localparam int MUL_W       = ADIST_W + WGT_W;
	localparam int RES_PROD_W  = CONF_W + WGT_W;
	localparam int RES_SHIFT   = 15;
	localparam int RES_TERM_W  = RES_PROD_W - RES_SHIFT;
	localparam int PC_W        = MUL_W + 1;

	localparam logic [CONF_W:0]      ONE_Q15   = (CONF_W + 1)'(32768);
	localparam logic [COST_W-1:0]    COST_MAX  = '1;
	localparam logic [SUM_W-1:0]     SUM_MAX   = '1;
	localparam logic [FIDX_W-1:0]    FIDX_MAX  = '1;
	localparam logic [NOTE_W-1:0]    REST_NOTE = '1;

	localparam logic [NREG_W-1:0]    RST_NOTE_LOW   = NREG_W'(36);
	localparam logic [NREG_W-1:0]    RST_NOTE_HIGH  = NREG_W'(96);
	localparam logic [COST_W-1:0]    RST_PENALTY    = COST_W'(2560);
	localparam logic [COST_W-1:0]    RST_CAP        = COST_W'(2560);
	localparam logic [WGT_W-1:0]     RST_DIST_WGT   = WGT_W'(256);
	localparam logic [CONF_W-1:0]    RST_CONF_FLOOR = CONF_W'(16384);
	localparam logic [WGT_W-1:0]     RST_RESID_WGT  = WGT_W'(256);
	localparam logic [WGT_W-1:0]     RST_PDIST_WGT  = WGT_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NOTE_LOW    = 3'd0,
		REG_NOTE_HIGH   = 3'd1,
		REG_PENALTY     = 3'd2,
		REG_CAP         = 3'd3,
		REG_DIST_WGT    = 3'd4,
		REG_CONF_FLOOR  = 3'd5,
		REG_RESID_WGT   = 3'd6,
		REG_PDIST_WGT   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [NREG_W-1:0] note_low;
		logic [NREG_W-1:0] note_high;
		logic [COST_W-1:0] mismatch_penalty;
		logic [COST_W-1:0] distance_cap;
		logic [WGT_W-1:0]  distance_weight;
		logic [CONF_W-1:0] confidence_floor;
		logic [WGT_W-1:0]  residual_weight;
		logic [WGT_W-1:0]  period_distance_weight;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic advance;
		logic last_issue;
		logic pipe_empty;
	} ctrl_status_t;

endpackage

// ===== src/psce_if.sv =====
// Valid/ready channel interfaces for frame features and per-state costs.
// Depends on psce_pkg for the field widths.
`timescale 1ns / 1ps

interface psce_in_if;
	import psce_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      table_start;
	logic                      frame_active;
	logic signed [NOTE_W-1:0]  local_note;
	logic                      period_found;
	logic        [CONF_W-1:0]  period_confidence;
	logic signed [NOTE_W-1:0]  period_note;

	modport source (
		output valid, table_start, frame_active, local_note,
		output period_found, period_confidence, period_note,
		input  ready
	);
	modport sink (
		input  valid, table_start, frame_active, local_note,
		input  period_found, period_confidence, period_note,
		output ready
	);
endinterface

interface psce_out_if;
	import psce_pkg::*;

	logic                          valid;
	logic                          ready;
	logic        [FIDX_W-1:0]      frame_index;
	logic        [STATE_IDX_W-1:0] state_index;
	logic signed [NOTE_W-1:0]      state_note;
	logic        [COST_W-1:0]      state_cost;
	logic        [SUM_W-1:0]       running_total;
	logic                          last_state;

	modport source (
		output valid, frame_index, state_index, state_note,
		output state_cost, running_total, last_state,
		input  ready
	);
	modport sink (
		input  valid, frame_index, state_index, state_note,
		input  state_cost, running_total, last_state,
		output ready
	);
endinterface

// ===== src/pitch_state_cost_engine_top.sv =====
// Pitch state cost engine, top level.
// Depends on psce_pkg, psce_if, psce_cfg, psce_ctrl, psce_datapath and the
// assertion macro header.
`timescale 1ns / 1ps
`include "pitch_state_cost_engine_top_assert.svh"

// One accepted frame produces N = span + 1 results, where span is
// note_high - note_low + 1 clamped to 63, or zero when note_high is below
// note_low; the rest state always comes first. States leave the scoring
// pipeline at one per cycle while the output side does not stall. A new
// frame is taken once the previous frame's states have all left the
// pipeline, while its last result may still wait in the output register.
// Registers are to be written by the user only while no frame is in
// progress; the block itself does not enforce it. There is no clearing
// pass after reset.
module pitch_state_cost_engine_top (
	input  logic                             clk,
	input  logic                             arst_n,
	psce_in_if.sink                          features,
	psce_out_if.source                       costs,
	input  logic                             write_enable,
	input  logic [psce_pkg::CFG_IDX_W-1:0]   reg_index,
	input  logic [psce_pkg::CFG_DATA_W-1:0]  write_data
);
	import psce_pkg::*;

	cfg_t         cfg;
	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	psce_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.cfg          (cfg)
	);

	psce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (features.valid),
		.in_ready (features.ready),
		.status   (status),
		.cmd      (cmd)
	);

	psce_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.table_start       (features.table_start),
		.frame_active      (features.frame_active),
		.local_note        (features.local_note),
		.period_found      (features.period_found),
		.period_confidence (features.period_confidence),
		.period_note       (features.period_note),
		.costs             (costs)
	);

	`PSCE_ASSERT_IMPLY(a_accept_drained, features.valid && features.ready, status.pipe_empty, "frame transfer while states are still in flight")
	`PSCE_ASSERT_IMPLY(a_rest_note, costs.valid && (costs.state_index == '0), costs.state_note == signed'(REST_NOTE), "rest state carries a note")
	`PSCE_ASSERT_IMPLY(a_total_covers_cost, costs.valid, costs.running_total >= SUM_W'(costs.state_cost), "running total below its own cost")
	`PSCE_ASSERT_NEXT(a_frame_restarts, costs.valid && costs.ready && costs.last_state, !costs.valid || (costs.state_index == '0), "frame did not restart at the rest state")

endmodule

// ===== src/psce_cfg.sv =====
// Configuration register file of the pitch state cost engine.
// Depends on psce_pkg for register codes, widths and reset values.
`timescale 1ns / 1ps

module psce_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_enable,
	input  logic [psce_pkg::CFG_IDX_W-1:0]     reg_index,
	input  logic [psce_pkg::CFG_DATA_W-1:0]    write_data,
	output psce_pkg::cfg_t                     cfg
);
	import psce_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.note_low               <= RST_NOTE_LOW;
			cfg_q.note_high              <= RST_NOTE_HIGH;
			cfg_q.mismatch_penalty       <= RST_PENALTY;
			cfg_q.distance_cap           <= RST_CAP;
			cfg_q.distance_weight        <= RST_DIST_WGT;
			cfg_q.confidence_floor       <= RST_CONF_FLOOR;
			cfg_q.residual_weight        <= RST_RESID_WGT;
			cfg_q.period_distance_weight <= RST_PDIST_WGT;
		end else if (write_enable) begin
			unique case (cfg_reg_t'(reg_index))
				REG_NOTE_LOW:   cfg_q.note_low <= write_data[NREG_W-1:0];
				REG_NOTE_HIGH:  cfg_q.note_high <= write_data[NREG_W-1:0];
				REG_PENALTY:    cfg_q.mismatch_penalty <= write_data[COST_W-1:0];
				REG_CAP:        cfg_q.distance_cap <= write_data[COST_W-1:0];
				REG_DIST_WGT:   cfg_q.distance_weight <= write_data[WGT_W-1:0];
				REG_CONF_FLOOR: cfg_q.confidence_floor <= write_data[CONF_W-1:0];
				REG_RESID_WGT:  cfg_q.residual_weight <= write_data[WGT_W-1:0];
				REG_PDIST_WGT:  cfg_q.period_distance_weight <= write_data[WGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/psce_ctrl.sv =====
// Frame sequencer of the pitch state cost engine: accepts a frame, issues
// its states into the datapath and waits for the pipeline to drain.
// Depends on psce_pkg for the command and status types.
`timescale 1ns / 1ps

module psce_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  psce_pkg::ctrl_status_t   status,
	output psce_pkg::ctrl_cmd_t      cmd
);
	import psce_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (status.advance && status.last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.pipe_empty) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.issue   = (state_q == ST_ISSUE);

endmodule

// ===== src/psce_datapath.sv =====
// Scoring datapath of the pitch state cost engine: frame registers, a
// three-stage per-state cost pipeline and the prefix sum memory.
// Depends on psce_pkg and on the psce_out_if interface.
`timescale 1ns / 1ps

module psce_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psce_pkg::cfg_t                   cfg,
	input  psce_pkg::ctrl_cmd_t              cmd,
	output psce_pkg::ctrl_status_t           status,
	input  logic                             table_start,
	input  logic                             frame_active,
	input  logic signed [psce_pkg::NOTE_W-1:0] local_note,
	input  logic                             period_found,
	input  logic [psce_pkg::CONF_W-1:0]      period_confidence,
	input  logic signed [psce_pkg::NOTE_W-1:0] period_note,
	psce_out_if.source                       costs
);
	import psce_pkg::*;

	localparam logic [NREG_W+1:0] SPAN_CAP = (NREG_W + 2)'(MAX_STATES - 1);

	// Frame registers.
	logic [FIDX_W-1:0]        frame_cnt_q;
	logic [FIDX_W-1:0]        fidx_q;
	logic                     active_q;
	logic                     loc_ok_q;
	logic                     per_en_q;
	logic signed [NOTE_W-1:0] local_q;
	logic signed [NOTE_W-1:0] pnote_q;
	logic [RES_PROD_W-1:0]    resid_prod_q;
	logic [STATE_W-1:0]       last_k_q;
	logic [STATE_W-1:0]       k_q;

	// Prefix sum memory and its valid bits.
	logic [SUM_W-1:0]         prefix_mem [MAX_STATES];
	logic [MAX_STATES-1:0]    prefix_vld_q;

	// Pipeline registers.
	logic                     vld_s1, vld_s2, out_valid_q;
	logic [STATE_W-1:0]       k_s1, k_s2;
	logic                     last_s1, last_s2;
	logic                     rest_s1;
	logic [NOTE_W-1:0]        note_s1, note_s2;
	logic [MUL_W-1:0]         dloc_s1, dper_s1;
	logic [SUM_W-1:0]         rd_s1, pre_s2;
	logic                     pv_s1;
	logic [COST_W-1:0]        cost_s2;

	logic [FIDX_W-1:0]        out_fidx_q;
	logic [STATE_IDX_W-1:0]   out_state_q;
	logic [NOTE_W-1:0]        out_note_q;
	logic [COST_W-1:0]        out_cost_q;
	logic [SUM_W-1:0]         out_total_q;
	logic                     out_last_q;

	logic                     adv;
	logic                     issue_go;
	logic                     mem_we;

	// Frame setup terms.
	logic [NREG_W:0]          note_diff;
	logic [NREG_W+1:0]        span_w;
	logic [STATE_W-1:0]       last_k_d;
	logic [CONF_W-1:0]        resid_w;
	logic [FIDX_W-1:0]        fcnt_base;

	// Stage 1 terms.
	logic [NOTE_W-1:0]        cand_u;
	logic signed [DIFF_W-1:0] cand_s, dl_s, dp_s;
	logic [ADIST_W-1:0]       ad_loc, ad_per;

	// Stage 2 and output terms.
	logic [COST_W-1:0]        base_cost, pc_sat, cost_d;
	logic [PC_W-1:0]          pc_sum;
	logic [SUM_W:0]           sum_w;
	logic [SUM_W-1:0]         total_d;

	assign adv      = !out_valid_q || costs.ready;
	assign issue_go = cmd.issue && adv;
	assign mem_we   = vld_s2 && adv;

	assign status.advance    = adv;
	assign status.last_issue = (k_q == last_k_q);
	assign status.pipe_empty = !vld_s1 && !vld_s2;

	always_comb begin
		note_diff = {1'b0, cfg.note_high} - {1'b0, cfg.note_low};
		span_w    = {1'b0, note_diff} + (NREG_W + 2)'(1);
		if (cfg.note_high < cfg.note_low) begin
			last_k_d = '0;
		end else if (span_w >= SPAN_CAP) begin
			last_k_d = STATE_W'(MAX_STATES - 1);
		end else begin
			last_k_d = span_w[STATE_W-1:0];
		end
		if ({1'b0, period_confidence} < ONE_Q15) begin
			resid_w = CONF_W'(ONE_Q15 - {1'b0, period_confidence});
		end else begin
			resid_w = '0;
		end
		fcnt_base = table_start ? '0 : frame_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
		end else if (cmd.capture) begin
			frame_cnt_q <= (fcnt_base == FIDX_MAX) ? fcnt_base : fcnt_base + FIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fidx_q       <= fcnt_base;
			active_q     <= frame_active;
			loc_ok_q     <= frame_active && !local_note[NOTE_W-1];
			per_en_q     <= period_found && frame_active &&
				(period_confidence >= cfg.confidence_floor);
			local_q      <= local_note;
			pnote_q      <= period_note;
			resid_prod_q <= RES_PROD_W'(resid_w) * RES_PROD_W'(cfg.residual_weight);
			last_k_q     <= last_k_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.capture) begin
			k_q <= '0;
		end else if (issue_go) begin
			k_q <= k_q + STATE_W'(1);
		end
	end

	// Stage 1: note distances and their weights, prefix memory read.
	always_comb begin
		cand_u = NOTE_W'(cfg.note_low) + NOTE_W'(k_q) - NOTE_W'(1);
		cand_s = signed'({2'b00, cand_u});
		dl_s   = cand_s - DIFF_W'(local_q);
		dp_s   = cand_s - DIFF_W'(pnote_q);
		ad_loc = dl_s[DIFF_W-1] ? ADIST_W'(-dl_s) : ADIST_W'(dl_s);
		ad_per = dp_s[DIFF_W-1] ? ADIST_W'(-dp_s) : ADIST_W'(dp_s);
	end

	// Stage 2: capped distance cost or penalty, period cost, the cheaper.
	always_comb begin
		if (rest_s1 || !loc_ok_q) begin
			base_cost = (rest_s1 && !active_q) ? '0 : cfg.mismatch_penalty;
		end else if (dloc_s1 < MUL_W'(cfg.distance_cap)) begin
			base_cost = dloc_s1[COST_W-1:0];
		end else begin
			base_cost = cfg.distance_cap;
		end
		pc_sum = PC_W'(resid_prod_q[RES_PROD_W-1:RES_SHIFT]) + PC_W'(dper_s1);
		pc_sat = (pc_sum > PC_W'(COST_MAX)) ? COST_MAX : pc_sum[COST_W-1:0];
		cost_d = (!rest_s1 && per_en_q && (pc_sat < base_cost)) ? pc_sat : base_cost;
	end

	// Output stage: saturating prefix sum.
	always_comb begin
		sum_w   = {1'b0, pre_s2} + (SUM_W + 1)'(cost_s2);
		total_d = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= cmd.issue;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1    <= k_q;
			last_s1 <= (k_q == last_k_q);
			rest_s1 <= (k_q == '0);
			note_s1 <= (k_q == '0) ? REST_NOTE : cand_u;
			dloc_s1 <= MUL_W'(ad_loc) * MUL_W'(cfg.distance_weight);
			dper_s1 <= MUL_W'(ad_per) * MUL_W'(cfg.period_distance_weight);
			rd_s1   <= prefix_mem[k_q];
			pv_s1   <= prefix_vld_q[k_q];

			k_s2    <= k_s1;
			last_s2 <= last_s1;
			note_s2 <= note_s1;
			cost_s2 <= cost_d;
			pre_s2  <= pv_s1 ? rd_s1 : '0;

			out_fidx_q  <= fidx_q;
			out_state_q <= STATE_IDX_W'(k_s2);
			out_note_q  <= note_s2;
			out_cost_q  <= cost_s2;
			out_total_q <= total_d;
			out_last_q  <= last_s2;
		end
		if (mem_we) begin
			prefix_mem[k_s2] <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_vld_q <= '0;
		end else begin
			if (cmd.capture && table_start) begin
				prefix_vld_q <= '0;
			end
			if (mem_we) begin
				prefix_vld_q[k_s2] <= 1'b1;
			end
		end
	end

	assign costs.valid         = out_valid_q;
	assign costs.frame_index   = out_fidx_q;
	assign costs.state_index   = out_state_q;
	assign costs.state_note    = signed'(out_note_q);
	assign costs.state_cost    = out_cost_q;
	assign costs.running_total = out_total_q;
	assign costs.last_state    = out_last_q;

endmodule
